### src/mre_pkg.sv
// shared types and constants of the mini risc execute unit
// opcode and status codes, front-to-back item word and result word
// no dependencies
`timescale 1ns / 1ps

package mre_pkg;

   localparam int NUM_REGS = 32;
   localparam int REG_W    = 5;
   localparam int WORD_W   = 32;
   localparam int PC_W     = 11;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;

   localparam logic [REG_W-1:0] ID_REG = 5'd31;
   localparam logic [PC_W-1:0]  PC_MAX = 11'd2047;

   localparam logic [OP_W-1:0] OP_ADD = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB = 3'd1;
   localparam logic [OP_W-1:0] OP_BNE = 3'd2;
   localparam logic [OP_W-1:0] OP_JAL = 3'd3;
   localparam logic [OP_W-1:0] OP_LW  = 3'd4;
   localparam logic [OP_W-1:0] OP_SW  = 3'd5;
   localparam logic [OP_W-1:0] OP_AND = 3'd6;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN_OP = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_TARGET = 2'd2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_PROGRAM_LENGTH = 1'b0;
   localparam logic [PC_W-1:0] LEN_RESET = 11'd1024;

   // classified instruction word as it waits in the issue queue
   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [REG_W-1:0]  dest_reg;
      logic [REG_W-1:0]  addr_a;
      logic [REG_W-1:0]  addr_b;
      logic              use_a;
      logic              use_b;
      logic [WORD_W-1:0] immediate;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } issue_type;

   typedef struct packed {
      logic pop;
      logic busy;
   } issue_ctl_type;

   typedef struct packed {
      logic [PC_W-1:0]     next_pc;
      logic [STATUS_W-1:0] status;
      logic                reg_written;
      logic [REG_W-1:0]    written_index;
      logic [WORD_W-1:0]   written_value;
      logic                program_finished;
   } rsp_type;

endpackage

### src/mre_front.sv
// front end: accepts request words, classifies operand use, two-entry issue queue
// depends on mre_pkg
`timescale 1ns / 1ps

module mre_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic [2:0]               req_opcode,
   input  logic [4:0]               req_dest_reg,
   input  logic [4:0]               req_src_reg_a,
   input  logic [4:0]               req_src_reg_b,
   input  logic signed [31:0]       req_immediate,
   output mre_pkg::issue_type       head,
   input  mre_pkg::issue_ctl_type   ctl
);

   mre_pkg::item_type dec;
   mre_pkg::item_type q_mem [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wptr_ff, rptr_ff;
   logic       accept;

   always_comb begin
      dec.opcode    = req_opcode;
      dec.dest_reg  = req_dest_reg;
      dec.addr_a    = req_src_reg_a;
      // store data rides the second read port
      dec.addr_b    = (req_opcode == mre_pkg::OP_SW) ? req_dest_reg : req_src_reg_b;
      dec.immediate = req_immediate;
      dec.use_a     = 1'b0;
      dec.use_b     = 1'b0;
      case (req_opcode)
         mre_pkg::OP_ADD, mre_pkg::OP_SUB, mre_pkg::OP_BNE, mre_pkg::OP_AND,
         mre_pkg::OP_SW: begin
            dec.use_a = 1'b1;
            dec.use_b = 1'b1;
         end
         mre_pkg::OP_LW: begin
            dec.use_a = 1'b1;
         end
         default: begin
            dec.use_a = 1'b0;
         end
      endcase
   end

   assign full   = (cnt_ff == 2'd2) || ctl.busy;
   assign accept = push && !full;

   always_comb begin
      case ({accept, ctl.pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (accept) begin
            wptr_ff <= !wptr_ff;
         end
         if (ctl.pop) begin
            rptr_ff <= !rptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_mem[wptr_ff] <= dec;
      end
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = q_mem[rptr_ff];

endmodule

### src/mre_csr.sv
// configuration register: program length over an apb-style port
// depends on mre_pkg
`timescale 1ns / 1ps

module mre_csr #(
   parameter int PROGRAM_DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mre_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [mre_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [mre_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output logic [mre_pkg::PC_W-1:0]          eff_length
);

   localparam logic [16:0] DEPTH_W = 17'(PROGRAM_DEPTH);

   logic [mre_pkg::PC_W-1:0] length_ff;
   logic                     hit;

   assign pready = 1'b1;
   assign hit    = (paddr[2] == mre_pkg::CSR_PROGRAM_LENGTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= mre_pkg::LEN_RESET;
      end else if (psel && penable && pwrite && pready && hit) begin
         length_ff <= pwdata[mre_pkg::PC_W-1:0];
      end
   end

   assign prdata = hit ? {21'b0, length_ff} : '0;

   // jump targets and finish are bounded by the smaller of length and depth
   assign eff_length = ({6'b0, length_ff} < DEPTH_W) ? length_ff
                                                     : DEPTH_W[mre_pkg::PC_W-1:0];

endmodule

### src/mre_rsp_queue.sv
// two-entry result queue in front of the rsp ports
// depends on mre_pkg
`timescale 1ns / 1ps

module mre_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  mre_pkg::rsp_type  wr_word,
   output logic              ready,
   input  logic              pop,
   output logic              empty,
   output mre_pkg::rsp_type  head
);

   mre_pkg::rsp_type q_mem [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wptr_ff, rptr_ff;
   logic       take;

   assign ready = (cnt_ff != 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign take  = pop && !empty;

   always_comb begin
      case ({wr_en, take})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (wr_en) begin
            wptr_ff <= !wptr_ff;
         end
         if (take) begin
            rptr_ff <= !rptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_mem[wptr_ff] <= wr_word;
      end
   end

   assign head = q_mem[rptr_ff];

endmodule

### src/mre_back.sv
// back end: register file, execute, address reduction, data store, writeback
// stages e, a, b, c, w with forwarding; depends on mre_pkg
`timescale 1ns / 1ps

module mre_back #(
   parameter int DATA_DEPTH = 1024,
   parameter int CORE_ID    = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mre_pkg::issue_type            head,
   output mre_pkg::issue_ctl_type        ctl,
   input  logic [mre_pkg::PC_W-1:0]      eff_length,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output mre_pkg::rsp_type              rsp
);

   localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
   localparam int RW = AW + 1;
   localparam bit IS_POW2 = ((DATA_DEPTH & (DATA_DEPTH - 1)) == 0);
   localparam logic [63:0] RECIP_WIDE = 64'h1_0000_0000 / 64'(DATA_DEPTH);
   localparam logic [31:0] RECIP = RECIP_WIDE[31:0];
   localparam logic [RW-1:0] DEPTH_R = RW'(DATA_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DATA_DEPTH - 1);
   localparam logic [31:0] ID_VALUE = 32'(CORE_ID);

   typedef struct packed {
      logic                             valid;
      logic                             wr;
      logic                             is_load;
      logic                             is_store;
      logic [mre_pkg::REG_W-1:0]        rd;
      logic [mre_pkg::WORD_W-1:0]       value;
      logic [mre_pkg::WORD_W-1:0]       sum;
      logic [RW-1:0]                    q_lo;
      logic [RW-1:0]                    prod;
      logic [mre_pkg::PC_W-1:0]         next_pc;
      logic [mre_pkg::STATUS_W-1:0]     status;
      logic                             finished;
   } stage_type;

   logic [31:0] rf_mem [mre_pkg::NUM_REGS];
   logic [mre_pkg::NUM_REGS-1:0] rf_valid_ff;
   logic [31:0] dmem [DATA_DEPTH];
   logic [31:0] dmem_rdata_ff;

   logic                      clr_busy_ff;
   logic [AW-1:0]             clr_addr_ff;
   logic [mre_pkg::PC_W-1:0]  pc_ff;

   logic               e_valid_ff;
   mre_pkg::item_type  e_item_ff;
   logic [31:0]        opa_ff, opb_ff;
   stage_type          a_ff, b_ff, c_ff, w_ff;
   stage_type          a_in, b_in, c_in, w_in;

   logic        advance, issue, hazard;
   logic        w_write;
   logic [31:0] w_data;
   logic [31:0] fwd_a, fwd_b;
   logic [mre_pkg::PC_W-1:0] pc_seq;
   logic        target_ok;
   logic [63:0] q_full;
   logic [RW-1:0] prod_w, rem0, rem1;
   logic [AW-1:0] dmem_addr;
   logic        e_is_load;

   // the whole pipe holds while a finished result cannot leave
   assign advance = !(w_ff.valid && !rsp_ready);
   assign w_data  = w_ff.is_load ? dmem_rdata_ff : w_ff.value;
   assign w_write = w_ff.valid && w_ff.wr && advance;

   // a load in stage e, a or b blocks a dependent issue
   assign e_is_load = e_valid_ff && (e_item_ff.opcode == mre_pkg::OP_LW);
   always_comb begin
      hazard = 1'b0;
      if (e_is_load && ((head.item.use_a && e_item_ff.dest_reg == head.item.addr_a) ||
                        (head.item.use_b && e_item_ff.dest_reg == head.item.addr_b))) begin
         hazard = 1'b1;
      end
      if (a_ff.valid && a_ff.is_load &&
          ((head.item.use_a && a_ff.rd == head.item.addr_a) ||
           (head.item.use_b && a_ff.rd == head.item.addr_b))) begin
         hazard = 1'b1;
      end
      if (b_ff.valid && b_ff.is_load &&
          ((head.item.use_a && b_ff.rd == head.item.addr_a) ||
           (head.item.use_b && b_ff.rd == head.item.addr_b))) begin
         hazard = 1'b1;
      end
   end

   assign issue    = head.valid && advance && !clr_busy_ff && !hazard;
   assign ctl.pop  = issue;
   assign ctl.busy = clr_busy_ff;

   // register file read with write-first bypass of writeback
   always_ff @(posedge clock) begin
      if (issue) begin
         e_item_ff <= head.item;
         if (w_write && w_ff.rd == head.item.addr_a) begin
            opa_ff <= w_data;
         end else if (rf_valid_ff[head.item.addr_a]) begin
            opa_ff <= rf_mem[head.item.addr_a];
         end else begin
            opa_ff <= (head.item.addr_a == mre_pkg::ID_REG) ? ID_VALUE : '0;
         end
         if (w_write && w_ff.rd == head.item.addr_b) begin
            opb_ff <= w_data;
         end else if (rf_valid_ff[head.item.addr_b]) begin
            opb_ff <= rf_mem[head.item.addr_b];
         end else begin
            opb_ff <= (head.item.addr_b == mre_pkg::ID_REG) ? ID_VALUE : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (w_write) begin
         rf_mem[w_ff.rd] <= w_data;
      end
   end

   // forwarding, youngest producer wins
   always_comb begin
      fwd_a = opa_ff;
      if (w_ff.valid && w_ff.wr && w_ff.rd == e_item_ff.addr_a) fwd_a = w_data;
      if (c_ff.valid && c_ff.wr && c_ff.rd == e_item_ff.addr_a) fwd_a = c_ff.value;
      if (b_ff.valid && b_ff.wr && b_ff.rd == e_item_ff.addr_a) fwd_a = b_ff.value;
      if (a_ff.valid && a_ff.wr && a_ff.rd == e_item_ff.addr_a) fwd_a = a_ff.value;
      fwd_b = opb_ff;
      if (w_ff.valid && w_ff.wr && w_ff.rd == e_item_ff.addr_b) fwd_b = w_data;
      if (c_ff.valid && c_ff.wr && c_ff.rd == e_item_ff.addr_b) fwd_b = c_ff.value;
      if (b_ff.valid && b_ff.wr && b_ff.rd == e_item_ff.addr_b) fwd_b = b_ff.value;
      if (a_ff.valid && a_ff.wr && a_ff.rd == e_item_ff.addr_b) fwd_b = a_ff.value;
   end

   assign pc_seq    = (pc_ff == mre_pkg::PC_MAX) ? mre_pkg::PC_MAX : pc_ff + 11'd1;
   assign target_ok = !e_item_ff.immediate[31] && (e_item_ff.immediate[30:11] == '0) &&
                      (e_item_ff.immediate[10:0] < eff_length);

   // execute
   always_comb begin
      a_in          = '0;
      a_in.valid    = e_valid_ff;
      a_in.rd       = e_item_ff.dest_reg;
      a_in.sum      = fwd_a + e_item_ff.immediate;
      a_in.next_pc  = pc_ff;
      a_in.status   = mre_pkg::STATUS_OK;
      case (e_item_ff.opcode)
         mre_pkg::OP_ADD: begin
            a_in.wr      = 1'b1;
            a_in.value   = fwd_a + fwd_b;
            a_in.next_pc = pc_seq;
         end
         mre_pkg::OP_SUB: begin
            a_in.wr      = 1'b1;
            a_in.value   = fwd_a - fwd_b;
            a_in.next_pc = pc_seq;
         end
         mre_pkg::OP_AND: begin
            a_in.wr      = 1'b1;
            a_in.value   = fwd_a & fwd_b;
            a_in.next_pc = pc_seq;
         end
         mre_pkg::OP_BNE: begin
            if (fwd_a != fwd_b) begin
               if (target_ok) begin
                  a_in.next_pc = e_item_ff.immediate[10:0];
               end else begin
                  a_in.status = mre_pkg::STATUS_BAD_TARGET;
               end
            end else begin
               a_in.next_pc = pc_seq;
            end
         end
         mre_pkg::OP_JAL: begin
            a_in.wr    = 1'b1;
            a_in.value = 32'(pc_ff) + 32'd1;
            if (target_ok) begin
               a_in.next_pc = e_item_ff.immediate[10:0];
            end else begin
               a_in.status = mre_pkg::STATUS_BAD_TARGET;
            end
         end
         mre_pkg::OP_LW: begin
            a_in.wr      = 1'b1;
            a_in.is_load = 1'b1;
            a_in.next_pc = pc_seq;
         end
         mre_pkg::OP_SW: begin
            a_in.is_store = 1'b1;
            a_in.value    = fwd_b;
            a_in.next_pc  = pc_seq;
         end
         default: begin
            a_in.status = mre_pkg::STATUS_UNKNOWN_OP;
         end
      endcase
      a_in.finished = (a_in.next_pc >= eff_length);
   end

   // address modulo depth: reciprocal estimate, then one correction
   assign q_full = 64'(a_ff.sum) * 64'(RECIP);
   always_comb begin
      b_in      = a_ff;
      b_in.q_lo = q_full[32 +: RW];
   end

   assign prod_w = RW'(b_ff.q_lo * DEPTH_R);
   always_comb begin
      c_in      = b_ff;
      c_in.prod = prod_w;
   end

   assign rem0 = c_ff.sum[RW-1:0] - c_ff.prod;
   assign rem1 = (rem0 >= DEPTH_R) ? rem0 - DEPTH_R : rem0;
   assign dmem_addr = (DATA_DEPTH == 1) ? '0 :
                      IS_POW2            ? c_ff.sum[AW-1:0] : rem1[AW-1:0];
   assign w_in = c_ff;

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         dmem[clr_addr_ff] <= '0;
      end else if (advance && c_ff.valid && c_ff.is_store) begin
         dmem[dmem_addr] <= c_ff.value;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dmem_rdata_ff <= dmem[dmem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff  <= 1'b0;
         a_ff.valid  <= 1'b0;
         b_ff.valid  <= 1'b0;
         c_ff.valid  <= 1'b0;
         w_ff.valid  <= 1'b0;
         pc_ff       <= '0;
         rf_valid_ff <= '0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         if (advance) begin
            e_valid_ff <= issue;
            a_ff       <= a_in;
            b_ff       <= b_in;
            c_ff       <= c_in;
            w_ff       <= w_in;
            if (e_valid_ff) begin
               pc_ff <= a_in.next_pc;
            end
         end
         if (w_write) begin
            rf_valid_ff[w_ff.rd] <= 1'b1;
         end
         if (clr_busy_ff) begin
            if (clr_addr_ff == LAST_ADDR) begin
               clr_busy_ff <= 1'b0;
            end else begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
            end
         end
      end
   end

   assign rsp_valid            = w_ff.valid;
   assign rsp.next_pc          = w_ff.next_pc;
   assign rsp.status           = w_ff.status;
   assign rsp.reg_written      = w_ff.wr;
   assign rsp.written_index    = w_ff.wr ? w_ff.rd : '0;
   assign rsp.written_value    = w_ff.wr ? w_data : '0;
   assign rsp.program_finished = w_ff.finished;

endmodule

### src/mini_risc_execute_unit.sv
// path: a word passes the issue queue, stages e, a, b, c and w, and the result queue
// throughput: one word per cycle while the result queue has room; a word that reads
//   the register an lw just ahead of it loads waits until the load leaves stage b
// reset: synchronous; after it the data store is swept to zero, one word a cycle,
//   with full held high; the csr port works throughout
// depends on mre_pkg, mre_front, mre_csr, mre_rsp_queue, mre_back
`timescale 1ns / 1ps

module mini_risc_execute_unit #(
   parameter int PROGRAM_DEPTH = 1024,
   parameter int DATA_DEPTH    = 1024,
   parameter int CORE_ID       = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [2:0]                     req_opcode,
   input  logic [4:0]                     req_dest_reg,
   input  logic [4:0]                     req_src_reg_a,
   input  logic [4:0]                     req_src_reg_b,
   input  logic signed [31:0]             req_immediate,
   input  logic                           pop,
   output logic                           empty,
   output logic [10:0]                    rsp_next_pc,
   output logic [1:0]                     rsp_status,
   output logic                           rsp_reg_written,
   output logic [4:0]                     rsp_written_index,
   output logic signed [31:0]             rsp_written_value,
   output logic                           rsp_program_finished,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mre_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mre_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mre_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   mre_pkg::issue_type      head;
   mre_pkg::issue_ctl_type  ctl;
   mre_pkg::rsp_type        back_word;
   mre_pkg::rsp_type        out_word;
   logic [mre_pkg::PC_W-1:0] eff_length;
   logic                    back_valid;
   logic                    rsp_ready;

   mre_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_opcode    (req_opcode),
      .req_dest_reg  (req_dest_reg),
      .req_src_reg_a (req_src_reg_a),
      .req_src_reg_b (req_src_reg_b),
      .req_immediate (req_immediate),
      .head          (head),
      .ctl           (ctl)
   );

   mre_csr #(
      .PROGRAM_DEPTH (PROGRAM_DEPTH)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .eff_length (eff_length)
   );

   mre_back #(
      .DATA_DEPTH (DATA_DEPTH),
      .CORE_ID    (CORE_ID)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .ctl        (ctl),
      .eff_length (eff_length),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (back_valid),
      .rsp        (back_word)
   );

   mre_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (back_valid && rsp_ready),
      .wr_word (back_word),
      .ready   (rsp_ready),
      .pop     (pop),
      .empty   (empty),
      .head    (out_word)
   );

   assign rsp_next_pc          = out_word.next_pc;
   assign rsp_status           = out_word.status;
   assign rsp_reg_written      = out_word.reg_written;
   assign rsp_written_index    = out_word.written_index;
   assign rsp_written_value    = out_word.written_value;
   assign rsp_program_finished = out_word.program_finished;

endmodule

### src/mre_checker.sv
// port-level checks on the execute unit, attached to the top level by bind
// depends on mre_pkg and mini_risc_execute_unit
`timescale 1ns / 1ps

module mre_checker (
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        pop,
   input logic        empty,
   input logic [10:0] rsp_next_pc,
   input logic [1:0]  rsp_status,
   input logic        rsp_reg_written,
   input logic [4:0]  rsp_written_index,
   input logic [31:0] rsp_written_value
);

   // data store sweep keeps the input closed right after reset
   a_full_after_reset: assert property (@(posedge clock) reset |=> full)
      else $error("full low right after reset");

   a_no_write_is_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_reg_written) |-> (rsp_written_index == 5'd0 && rsp_written_value == 32'd0))
      else $error("no register write but index or value nonzero");

   a_unknown_no_write: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status == mre_pkg::STATUS_UNKNOWN_OP) |-> !rsp_reg_written)
      else $error("unknown opcode wrote a register");

   a_held_word: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_next_pc) && $stable(rsp_written_value)))
      else $error("waiting result word changed");

endmodule

bind mini_risc_execute_unit mre_checker u_mre_checker (
   .clock             (clock),
   .reset             (reset),
   .full              (full),
   .pop               (pop),
   .empty             (empty),
   .rsp_next_pc       (rsp_next_pc),
   .rsp_status        (rsp_status),
   .rsp_reg_written   (rsp_reg_written),
   .rsp_written_index (rsp_written_index),
   .rsp_written_value (rsp_written_value)
);
